// File: design/bsa_pkg.sv
package bsa_pkg;

  // Default structural sizes handed to the top level
  localparam int MAX_VIEWS_DEF  = 4;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed field widths of the ports
  localparam int COORD_W    = 20;
  localparam int CONF_W     = 16;
  localparam int CELL_W     = 40;
  localparam int VIEW_IN_W  = 2;
  localparam int RC_IN_W    = 6;
  localparam int ACT_W      = 3;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Command fields sized for the largest legal parameter values
  localparam int IDX_MAX_W  = 10;
  localparam int VIEW_MAX_W = 4;
  localparam int FRAC_MAX_W = 12;

  // Entries in the command queue between front and back
  localparam int Q_DEPTH = 2;

  // Register reset values
  localparam logic [ACT_W-1:0] ACTIVE_VIEWS_RST = ACT_W'(4);
  localparam logic [DIM_W-1:0] IMG_HEIGHT_RST   = DIM_W'(64);
  localparam logic [DIM_W-1:0] IMG_WIDTH_RST    = DIM_W'(64);

  // Function code of an input item
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_VIEWS = 2'd0,
    CFG_IMG_HEIGHT   = 2'd1,
    CFG_IMG_WIDTH    = 2'd2
  } cfg_idx_e;

  // Work carried from front to back
  typedef enum logic [1:0] {
    OP_SPLAT = 2'd0,
    OP_READ  = 2'd1,
    OP_ZERO  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [VIEW_MAX_W-1:0] view;
    logic [IDX_MAX_W-1:0]  row;   // floor row for a splat, cell row for a read
    logic [IDX_MAX_W-1:0]  col;
    logic [3:0]            mask;  // in-range corners by corner index, index bit1 = lower row, bit0 = right col
    logic [FRAC_MAX_W-1:0] fx;
    logic [FRAC_MAX_W-1:0] fy;
    logic [CONF_W-1:0]     conf;
  } cmd_t;

endpackage

// File: design/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bsa_front.sv
module bsa_front #(
  parameter int MAX_VIEWS  = bsa_pkg::MAX_VIEWS_DEF,
  parameter int MAX_HEIGHT = bsa_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = bsa_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS  = bsa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                func_i,
  input  logic [bsa_pkg::VIEW_IN_W-1:0]       view_i,
  input  logic signed [bsa_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [bsa_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [bsa_pkg::CONF_W-1:0]          conf_i,
  input  logic [bsa_pkg::RC_IN_W-1:0]         read_row_i,
  input  logic [bsa_pkg::RC_IN_W-1:0]         read_col_i,
  input  logic                                cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                push_o,
  output bsa_pkg::cmd_t                       cmd_o
);

  logic [bsa_pkg::ACT_W-1:0] active_views_q;
  logic [bsa_pkg::DIM_W-1:0] img_height_q;
  logic [bsa_pkg::DIM_W-1:0] img_width_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_views_q <= bsa_pkg::ACTIVE_VIEWS_RST;
      img_height_q   <= bsa_pkg::IMG_HEIGHT_RST;
      img_width_q    <= bsa_pkg::IMG_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (bsa_pkg::cfg_idx_e'(cfg_idx_i))
        bsa_pkg::CFG_ACTIVE_VIEWS: active_views_q <= cfg_wdata_i[bsa_pkg::ACT_W-1:0];
        bsa_pkg::CFG_IMG_HEIGHT:   img_height_q   <= cfg_wdata_i[bsa_pkg::DIM_W-1:0];
        bsa_pkg::CFG_IMG_WIDTH:    img_width_q    <= cfg_wdata_i[bsa_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Floor cell and fraction of each coordinate (arithmetic shift floors)
  logic signed [bsa_pkg::COORD_W-1:0] x0;
  logic signed [bsa_pkg::COORD_W-1:0] y0;
  logic [FRAC_BITS-1:0]               fx;
  logic [FRAC_BITS-1:0]               fy;

  assign x0 = coord_x_i >>> FRAC_BITS;
  assign y0 = coord_y_i >>> FRAC_BITS;
  assign fx = coord_x_i[FRAC_BITS-1:0];
  assign fy = coord_y_i[FRAC_BITS-1:0];

  // Classification: liveness, bounds and corner mask
  int   h_lim, w_lim, v_lim, x0_n, y0_n;
  logic live;
  logic row_ok0, row_ok1, col_ok0, col_ok1;
  logic read_ok;
  logic [3:0] mask;

  always_comb begin
    h_lim = (int'(img_height_q) > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_height_q);
    w_lim = (int'(img_width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(img_width_q);
    v_lim = (int'(active_views_q) > MAX_VIEWS) ? MAX_VIEWS : int'(active_views_q);
    x0_n  = int'(x0);
    y0_n  = int'(y0);
    live  = int'(view_i) < v_lim;

    row_ok0 = (y0_n >= 0) && (y0_n < h_lim);
    row_ok1 = (y0_n + 1 >= 0) && (y0_n + 1 < h_lim);
    col_ok0 = (x0_n >= 0) && (x0_n < w_lim);
    col_ok1 = (x0_n + 1 >= 0) && (x0_n + 1 < w_lim);
    mask    = {row_ok1 & col_ok1, row_ok1 & col_ok0, row_ok0 & col_ok1, row_ok0 & col_ok0};

    read_ok = live && (int'(read_row_i) < h_lim) && (int'(read_col_i) < w_lim);
  end

  // Command build; dead, out-of-range or zero-fraction splats never enter the queue
  always_comb begin
    cmd_o      = '0;
    cmd_o.view = bsa_pkg::VIEW_MAX_W'(view_i);
    cmd_o.conf = conf_i;
    cmd_o.fx   = bsa_pkg::FRAC_MAX_W'(fx);
    cmd_o.fy   = bsa_pkg::FRAC_MAX_W'(fy);
    if (func_i == bsa_pkg::FUNC_READ) begin
      cmd_o.op  = read_ok ? bsa_pkg::OP_READ : bsa_pkg::OP_ZERO;
      cmd_o.row = bsa_pkg::IDX_MAX_W'(read_row_i);
      cmd_o.col = bsa_pkg::IDX_MAX_W'(read_col_i);
      push_o    = accept_i;
    end else begin
      cmd_o.op   = bsa_pkg::OP_SPLAT;
      cmd_o.row  = bsa_pkg::IDX_MAX_W'(y0_n);
      cmd_o.col  = bsa_pkg::IDX_MAX_W'(x0_n);
      cmd_o.mask = mask;
      // a zero fraction on either axis: all four weights vanish
      push_o     = accept_i && live && (fx != '0) && (fy != '0) && (mask != '0);
    end
  end

endmodule

// File: design/bsa_queue.sv
module bsa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsa_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output bsa_pkg::cmd_t head_o
);

  localparam int PTR_W = (bsa_pkg::Q_DEPTH > 1) ? $clog2(bsa_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(bsa_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(bsa_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(bsa_pkg::Q_DEPTH);

  bsa_pkg::cmd_t    entry_q [bsa_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  // Pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_FULL);
  assign head_o  = entry_q[rptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("command queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("command queue popped while empty");

endmodule

// File: design/bsa_back.sv
module bsa_back #(
  parameter int MAX_VIEWS  = bsa_pkg::MAX_VIEWS_DEF,
  parameter int MAX_HEIGHT = bsa_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = bsa_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS  = bsa_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  bsa_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        clearing_o,
  output logic                        done_o,
  output logic [bsa_pkg::CELL_W-1:0]  cell_weight_o
);

  localparam int VIEW_W    = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = VIEW_W + ROW_W + COL_W;
  localparam int DEPTH     = 2 ** ADDR_W;
  localparam int CW        = bsa_pkg::CELL_W;
  localparam int WPROD_W   = 2 * FRAC_BITS;
  localparam int PROD_W    = WPROD_W + bsa_pkg::CONF_W;
  localparam int PROD_FRAC = 2 * FRAC_BITS + 15;
  localparam int SH_L      = (PROD_FRAC < 31) ? 31 - PROD_FRAC : 0;
  localparam int SH_R      = (PROD_FRAC > 31) ? PROD_FRAC - 31 : 0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PICK,
    S_MUL,
    S_WR,
    S_READ,
    S_RESULT
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  bsa_pkg::cmd_t       cmd_q;
  logic [3:0]          mask_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [WPROD_W-1:0]  wprod_q;
  logic [CW-1:0]       amt_q;
  logic                done_q;
  logic [CW-1:0]       cell_q;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CW-1:0]       ram_wdata, ram_rdata;

  // Next corner: lowest set bit of the remaining mask
  logic [1:0] corner;
  always_comb begin
    if (mask_q[0]) begin
      corner = 2'd0;
    end else if (mask_q[1]) begin
      corner = 2'd1;
    end else if (mask_q[2]) begin
      corner = 2'd2;
    end else begin
      corner = 2'd3;
    end
  end

  // Corner address and opposite distances
  logic [VIEW_W-1:0]    view_a;
  logic [ROW_W-1:0]     row_c;
  logic [COL_W-1:0]     col_c;
  logic [ADDR_W-1:0]    corner_addr, read_addr;
  logic [FRAC_BITS-1:0] fx, fy, dx, dy;

  assign view_a      = cmd_q.view[VIEW_W-1:0];
  assign row_c       = cmd_q.row[ROW_W-1:0] + ROW_W'(corner[1]);
  assign col_c       = cmd_q.col[COL_W-1:0] + COL_W'(corner[0]);
  assign corner_addr = {view_a, row_c, col_c};
  assign read_addr   = {view_a, cmd_q.row[ROW_W-1:0], cmd_q.col[COL_W-1:0]};
  assign fx          = cmd_q.fx[FRAC_BITS-1:0];
  assign fy          = cmd_q.fy[FRAC_BITS-1:0];
  // fraction is nonzero here, so 2^F - f fits in F bits
  assign dx          = corner[0] ? fx : (~fx + FRAC_BITS'(1));
  assign dy          = corner[1] ? fy : (~fy + FRAC_BITS'(1));

  // Weight times confidence, aligned to 31 fraction bits
  logic [PROD_W-1:0] prod;
  logic [CW-1:0]     amt;
  assign prod = PROD_W'(wprod_q) * PROD_W'(cmd_q.conf);
  assign amt  = (CW'(prod) << SH_L) >> SH_R;

  // Saturating accumulate
  logic [CW:0]   sum;
  logic [CW-1:0] sum_sat;
  assign sum     = {1'b0, ram_rdata} + {1'b0, amt_q};
  assign sum_sat = sum[CW] ? '1 : sum[CW-1:0];

  // Map memory port control
  always_comb begin
    ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
    ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
    ram_wdata = (state_q == S_CLEAR) ? '0 : sum_sat;
    ram_re    = ((state_q == S_PICK) && (mask_q != '0)) || (state_q == S_READ);
    ram_raddr = (state_q == S_READ) ? read_addr : corner_addr;
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // Result strobe: a read leaving S_RESULT, or a zero read taken from the queue
  logic done_d;
  assign done_d = (state_q == S_RESULT) ||
                  ((state_q == S_IDLE) && q_valid_i &&
                   (q_cmd_i.op != bsa_pkg::OP_SPLAT) && (q_cmd_i.op != bsa_pkg::OP_READ));

  // Sequencer: clearing pass, then one command at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cmd_q   <= '0;
      mask_q  <= '0;
      addr_q  <= '0;
      wprod_q <= '0;
      amt_q   <= '0;
      done_q  <= 1'b0;
      cell_q  <= '0;
    end else begin
      done_q <= done_d;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q  <= q_cmd_i;
            mask_q <= q_cmd_i.mask;
            case (q_cmd_i.op)
              bsa_pkg::OP_SPLAT: state_q <= S_PICK;
              bsa_pkg::OP_READ:  state_q <= S_READ;
              default: begin
                cell_q <= '0;
              end
            endcase
          end
        end
        S_PICK: begin
          if (mask_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            mask_q[corner] <= 1'b0;
            addr_q         <= corner_addr;
            wprod_q        <= dx * dy;
            state_q        <= S_MUL;
          end
        end
        S_MUL: begin
          amt_q   <= amt;
          state_q <= S_WR;
        end
        S_WR: begin
          state_q <= S_PICK;
        end
        S_READ: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          cell_q  <= ram_rdata;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bsa_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign clearing_o    = (state_q == S_CLEAR);
  assign done_o        = done_q;
  assign cell_weight_o = cell_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("map read and write in the same cycle");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> $past(ram_re, 2))
    else $error("accumulate write without a matching read");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == S_CLEAR) |-> clr_q == '0)
    else $error("clearing pass ended early");

endmodule

// File: design/bilinear_splat_accumulator.sv
// Bilinear splat accumulator. An item is taken at a rising edge with start high and
// busy low. A splat adds weight times confidence into up to four cells of the view's
// map; a read returns one cell on cell_weight_o, flagged by done_o for exactly one cycle.
// done_o cannot be held off: the receiver must take each result as it appears. After
// reset busy stays high for a clearing pass that zeroes every map entry, with the view,
// row and column address fields each clog2 of their maximum (the view field at least one
// bit): 16384 entries at the defaults. Items go into a two-entry command queue; the map
// takes one access per cycle, so each in-range corner costs a read-modify-write through
// S_PICK, S_MUL and S_WR, and a splat holds the back end until its last corner is
// written. An in-range read passes through S_READ and S_RESULT to the registered
// done_o, one out of range or at an inactive view goes straight from S_IDLE. Splats
// at an inactive view, at an exact integer coordinate or wholly outside the image
// leave no work behind. Configuration may be written only while no item is in flight.
module bilinear_splat_accumulator #(
  parameter int MAX_VIEWS  = bsa_pkg::MAX_VIEWS_DEF,
  parameter int MAX_HEIGHT = bsa_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = bsa_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS  = bsa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [bsa_pkg::VIEW_IN_W-1:0]       view_i,
  input  logic signed [bsa_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [bsa_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [bsa_pkg::CONF_W-1:0]          conf_i,
  input  logic [bsa_pkg::RC_IN_W-1:0]         read_row_i,
  input  logic [bsa_pkg::RC_IN_W-1:0]         read_col_i,
  input  logic                                cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                done_o,
  output logic [bsa_pkg::CELL_W-1:0]          cell_weight_o
);

  logic          push, pop, q_valid, q_full, clearing;
  bsa_pkg::cmd_t push_cmd, head_cmd;

  // Hold off transfers while clearing or when the queue is full
  assign busy = clearing || q_full;

  bsa_front #(
    .MAX_VIEWS  (MAX_VIEWS),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (start && !busy),
    .func_i      (func_i),
    .view_i      (view_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .conf_i      (conf_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bsa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .full_o     (q_full),
    .head_o     (head_cmd)
  );

  bsa_back #(
    .MAX_VIEWS  (MAX_VIEWS),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .cell_weight_o (cell_weight_o)
  );

endmodule
